/* rtl/trsb_pkg.sv */
// Shared types, codes and reset values of the traffic rate status blinker.
package trsb_pkg;

    localparam int BRIGHT_W   = 8;
    localparam int BYTES_W    = 32;
    localparam int INTERVAL_W = 16;
    localparam int PROD_W     = BYTES_W + INTERVAL_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int TIMER_BITS_DEF = 16;
    localparam int Q_DEPTH_DEF    = 2;

    // item kinds
    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_TRAFFIC = 2'd1;
    localparam logic [1:0] MODE_STATE   = 2'd2;
    localparam logic [1:0] MODE_NOP     = 2'd3;

    // display states
    localparam logic [1:0] DISP_STANDBY   = 2'd0;
    localparam logic [1:0] DISP_ERROR     = 2'd1;
    localparam logic [1:0] DISP_RECONNECT = 2'd2;
    localparam logic [1:0] DISP_ACTIVE    = 2'd3;

    // traffic classes
    localparam logic [1:0] TC_FAST   = 2'd0;
    localparam logic [1:0] TC_SLOW   = 2'd1;
    localparam logic [1:0] TC_INTERP = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BRIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAF_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAF_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_INT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_INT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RECON_INT  = 3'd5;

    // register reset values
    localparam logic [BRIGHT_W-1:0]   RST_MAX_BRIGHT = 8'd127;
    localparam logic [BYTES_W-1:0]    RST_TRAF_LOW   = 32'd1000;
    localparam logic [BYTES_W-1:0]    RST_TRAF_HIGH  = 32'd100000;
    localparam logic [INTERVAL_W-1:0] RST_FAST_INT   = 16'd50;
    localparam logic [INTERVAL_W-1:0] RST_SLOW_INT   = 16'd1000;
    localparam logic [INTERVAL_W-1:0] RST_RECON_INT  = 16'd500;

    typedef struct packed {
        logic [BRIGHT_W-1:0]   drive_level;
        logic [BYTES_W-1:0]    traffic_low;
        logic [BYTES_W-1:0]    traffic_high;
        logic [INTERVAL_W-1:0] fast_interval_ms;
        logic [INTERVAL_W-1:0] slow_interval_ms;
        logic [INTERVAL_W-1:0] reconnect_interval_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         new_state;
        logic [1:0]         tclass;
        logic [BYTES_W-1:0] diff;
    } t_cmd;

    typedef struct packed {
        logic [BRIGHT_W-1:0]   red;
        logic [BRIGHT_W-1:0]   green;
        logic [BRIGHT_W-1:0]   blue;
        logic                  lit;
        logic [INTERVAL_W-1:0] interval_ms;
    } t_res;

endpackage

/* rtl/trsb_fifo.sv */
// Small register queue used between the front, the back and the result port.
module trsb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = trsb_pkg::Q_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= (r_wp == LAST) ? '0 : r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= (r_rp == LAST) ? '0 : r_rp + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

/* rtl/trsb_front.sv */
// Front end: decodes an input item and classifies traffic against the thresholds.
module trsb_front (
    input  trsb_pkg::t_cfg                      i_cfg,
    input  logic [1:0]                          i_mode,
    input  logic [trsb_pkg::BYTES_W-1:0]        i_traffic_bytes,
    input  logic [1:0]                          i_new_state,
    output trsb_pkg::t_cmd                      o_cmd
);
    always_comb begin
        o_cmd.new_state = i_new_state;
        o_cmd.diff      = i_traffic_bytes - i_cfg.traffic_low;
        unique case (i_mode)
            trsb_pkg::MODE_TICK:    o_cmd.kind = trsb_pkg::MODE_TICK;
            trsb_pkg::MODE_TRAFFIC: o_cmd.kind = trsb_pkg::MODE_TRAFFIC;
            trsb_pkg::MODE_STATE:   o_cmd.kind = trsb_pkg::MODE_STATE;
            default:                o_cmd.kind = trsb_pkg::MODE_NOP;
        endcase
        // high threshold wins when the thresholds are out of order
        priority if (i_traffic_bytes >= i_cfg.traffic_high) begin
            o_cmd.tclass = trsb_pkg::TC_FAST;
        end else if (i_traffic_bytes <= i_cfg.traffic_low) begin
            o_cmd.tclass = trsb_pkg::TC_SLOW;
        end else begin
            o_cmd.tclass = trsb_pkg::TC_INTERP;
        end
    end
endmodule

/* rtl/trsb_back.sv */
// Back end: lamp state, blink timer and the serial interval interpolation.
module trsb_back #(
    parameter int TIMER_BITS = trsb_pkg::TIMER_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  trsb_pkg::t_cfg i_cfg,
    input  logic           i_cmd_empty,
    input  trsb_pkg::t_cmd i_cmd,
    output logic           o_cmd_pop,
    input  logic           i_res_full,
    output logic           o_res_push,
    output trsb_pkg::t_res o_res
);
    localparam int IW    = trsb_pkg::INTERVAL_W;
    localparam int BW    = trsb_pkg::BYTES_W;
    localparam int CMP_W = (TIMER_BITS > IW) ? TIMER_BITS : IW;
    localparam int CNT_W = $clog2(IW);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [1:0]            r_mode, n_mode;
    logic                  r_lamp, n_lamp;
    logic [TIMER_BITS-1:0] r_elapsed, n_elapsed;
    logic [IW-1:0]         r_interval, n_interval;

    logic [BW-1:0]         r_diff, r_range, r_rem;
    logic [IW-1:0]         r_span, r_lo;
    logic                  r_up;
    logic [CNT_W-1:0]      r_cnt;

    logic                  go_div, do_simple, finish;
    logic                  blink;
    logic [IW-1:0]         limit;
    logic [BW:0]           trial;
    logic                  ge;
    logic [BW-1:0]         rem_next;

    assign go_div = (r_state == ST_IDLE) && !i_cmd_empty
                    && (i_cmd.kind == trsb_pkg::MODE_TRAFFIC)
                    && (i_cmd.tclass == trsb_pkg::TC_INTERP)
                    && (r_mode == trsb_pkg::DISP_ACTIVE);
    assign do_simple = (r_state == ST_IDLE) && !i_cmd_empty && !go_div && !i_res_full;
    assign finish    = (r_state == ST_DONE) && !i_res_full;
    assign o_cmd_pop  = go_div || do_simple;
    assign o_res_push = do_simple || finish;

    // restoring divide step, quotient bits shift into r_lo
    assign trial    = {r_rem, r_lo[IW-1]};
    assign ge       = (trial >= {1'b0, r_range});
    assign rem_next = ge ? BW'(trial - {1'b0, r_range}) : trial[BW-1:0];

    always_comb begin
        n_mode     = r_mode;
        n_lamp     = r_lamp;
        n_elapsed  = r_elapsed;
        n_interval = r_interval;
        blink      = 1'b0;
        limit      = r_interval;
        if (r_state == ST_DONE) begin
            n_interval = r_up ? i_cfg.slow_interval_ms + r_lo
                              : i_cfg.slow_interval_ms - r_lo;
        end else begin
            unique case (i_cmd.kind)
                trsb_pkg::MODE_TICK: begin
                    if (r_elapsed != '1) begin
                        n_elapsed = r_elapsed + 1'b1;
                    end
                    if (r_mode == trsb_pkg::DISP_RECONNECT) begin
                        blink = 1'b1;
                        limit = i_cfg.reconnect_interval_ms;
                    end else if (r_mode == trsb_pkg::DISP_ACTIVE) begin
                        blink = 1'b1;
                    end
                    if (blink && (CMP_W'(n_elapsed) >= CMP_W'(limit))) begin
                        n_lamp    = !r_lamp;
                        n_elapsed = '0;
                    end
                end
                trsb_pkg::MODE_TRAFFIC: begin
                    if (r_mode == trsb_pkg::DISP_ACTIVE) begin
                        if (i_cmd.tclass == trsb_pkg::TC_FAST) begin
                            n_interval = i_cfg.fast_interval_ms;
                        end else if (i_cmd.tclass == trsb_pkg::TC_SLOW) begin
                            n_interval = i_cfg.slow_interval_ms;
                        end
                    end
                end
                trsb_pkg::MODE_STATE: n_mode = i_cmd.new_state;
                default: ;
            endcase
        end
        if (n_mode == trsb_pkg::DISP_STANDBY || n_mode == trsb_pkg::DISP_ERROR) begin
            n_lamp = 1'b1;
        end
    end

    always_comb begin
        o_res.red         = '0;
        o_res.green       = '0;
        o_res.blue        = '0;
        o_res.lit         = n_lamp;
        o_res.interval_ms = n_interval;
        unique case (n_mode)
            trsb_pkg::DISP_STANDBY: o_res.blue = i_cfg.drive_level;
            trsb_pkg::DISP_ERROR:   o_res.red  = i_cfg.drive_level;
            trsb_pkg::DISP_RECONNECT: begin
                if (n_lamp) begin
                    o_res.red   = i_cfg.drive_level;
                    o_res.green = i_cfg.drive_level;
                end
            end
            default: begin
                if (n_lamp) begin
                    o_res.green = i_cfg.drive_level;
                end
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (go_div) n_state = ST_MUL;
            ST_MUL:  n_state = ST_DIV;
            ST_DIV:  if (r_cnt == CNT_W'(IW - 1)) n_state = ST_DONE;
            default: if (finish) n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_mode     <= trsb_pkg::DISP_STANDBY;
            r_lamp     <= 1'b0;
            r_elapsed  <= '0;
            r_interval <= trsb_pkg::RST_SLOW_INT;
            r_cnt      <= '0;
        end else begin
            r_state <= n_state;
            if (o_res_push) begin
                r_mode     <= n_mode;
                r_lamp     <= n_lamp;
                r_elapsed  <= n_elapsed;
                r_interval <= n_interval;
            end
            if (r_state == ST_DIV) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go_div) begin
            r_diff  <= i_cmd.diff;
            r_range <= i_cfg.traffic_high - i_cfg.traffic_low;
            r_up    <= i_cfg.slow_interval_ms < i_cfg.fast_interval_ms;
            r_span  <= (i_cfg.slow_interval_ms >= i_cfg.fast_interval_ms)
                       ? i_cfg.slow_interval_ms - i_cfg.fast_interval_ms
                       : i_cfg.fast_interval_ms - i_cfg.slow_interval_ms;
        end
        if (r_state == ST_MUL) begin
            {r_rem, r_lo} <= trsb_pkg::PROD_W'(r_diff) * trsb_pkg::PROD_W'(r_span);
        end else if (r_state == ST_DIV) begin
            r_rem <= rem_next;
            r_lo  <= {r_lo[IW-2:0], ge};
        end
    end
endmodule

/* rtl/traffic_rate_status_blinker_unit.sv */
// Top level of the traffic rate status blinker: registers, queues, front and back.
//
//  channel | direction | handshake            | payload
//  input   | in        | push / full          | i_mode, i_traffic_bytes, i_new_state
//  result  | out       | empty / pop          | o_red, o_green, o_blue, o_lit, o_interval_ms
//  config  | in        | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// Tick, state change and plain traffic items are handled in the back end's idle state,
// popped and answered together unless the result queue is full. A traffic report
// between the thresholds while active takes a multiply step and a 16-step serial
// divide in the back end. Reset is synchronous; no clearing pass.
// Each side stalls on its own through a Q_DEPTH-entry (two by default) item queue before and after the back end.
module traffic_rate_status_blinker_unit #(
    parameter int TIMER_BITS = trsb_pkg::TIMER_BITS_DEF,
    parameter int Q_DEPTH    = trsb_pkg::Q_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [1:0]                          i_mode,
    input  logic [trsb_pkg::BYTES_W-1:0]        i_traffic_bytes,
    input  logic [1:0]                          i_new_state,
    output logic                                empty,
    input  logic                                pop,
    output logic [trsb_pkg::BRIGHT_W-1:0]       o_red,
    output logic [trsb_pkg::BRIGHT_W-1:0]       o_green,
    output logic [trsb_pkg::BRIGHT_W-1:0]       o_blue,
    output logic                                o_lit,
    output logic [trsb_pkg::INTERVAL_W-1:0]     o_interval_ms,
    input  logic                                i_cfg_we,
    input  logic [trsb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [trsb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    localparam int CMD_W = $bits(trsb_pkg::t_cmd);
    localparam int RES_W = $bits(trsb_pkg::t_res);

    trsb_pkg::t_cfg r_cfg;
    trsb_pkg::t_cmd front_cmd, q_cmd;
    trsb_pkg::t_res back_res, q_res;
    logic           cmd_empty, cmd_pop, res_full, res_push;
    logic [CMD_W-1:0] cmd_rdata;
    logic [RES_W-1:0] res_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drive_level           <= trsb_pkg::RST_MAX_BRIGHT;
            r_cfg.traffic_low           <= trsb_pkg::RST_TRAF_LOW;
            r_cfg.traffic_high          <= trsb_pkg::RST_TRAF_HIGH;
            r_cfg.fast_interval_ms      <= trsb_pkg::RST_FAST_INT;
            r_cfg.slow_interval_ms      <= trsb_pkg::RST_SLOW_INT;
            r_cfg.reconnect_interval_ms <= trsb_pkg::RST_RECON_INT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                trsb_pkg::CFG_MAX_BRIGHT:
                    r_cfg.drive_level <= i_cfg_data[trsb_pkg::BRIGHT_W-1:0];
                trsb_pkg::CFG_TRAF_LOW:
                    r_cfg.traffic_low <= i_cfg_data[trsb_pkg::BYTES_W-1:0];
                trsb_pkg::CFG_TRAF_HIGH:
                    r_cfg.traffic_high <= i_cfg_data[trsb_pkg::BYTES_W-1:0];
                trsb_pkg::CFG_FAST_INT:
                    r_cfg.fast_interval_ms <= i_cfg_data[trsb_pkg::INTERVAL_W-1:0];
                trsb_pkg::CFG_SLOW_INT:
                    r_cfg.slow_interval_ms <= i_cfg_data[trsb_pkg::INTERVAL_W-1:0];
                trsb_pkg::CFG_RECON_INT:
                    r_cfg.reconnect_interval_ms <= i_cfg_data[trsb_pkg::INTERVAL_W-1:0];
                default: ;
            endcase
        end
    end

    trsb_front u_front (
        .i_cfg           (r_cfg),
        .i_mode          (i_mode),
        .i_traffic_bytes (i_traffic_bytes),
        .i_new_state     (i_new_state),
        .o_cmd           (front_cmd)
    );

    trsb_fifo #(.WIDTH(CMD_W), .DEPTH(Q_DEPTH)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_rdata (cmd_rdata)
    );

    assign q_cmd = trsb_pkg::t_cmd'(cmd_rdata);

    trsb_back #(.TIMER_BITS(TIMER_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    trsb_fifo #(.WIDTH(RES_W), .DEPTH(Q_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_rdata (res_rdata)
    );

    assign q_res         = trsb_pkg::t_res'(res_rdata);
    assign o_red         = q_res.red;
    assign o_green       = q_res.green;
    assign o_blue        = q_res.blue;
    assign o_lit         = q_res.lit;
    assign o_interval_ms = q_res.interval_ms;

    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    a_cmd_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("item popped from an empty queue");

    a_blue_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_blue != '0) |-> (o_red == '0 && o_green == '0))
        else $error("blue drive mixed with another colour");

    a_dark_lamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_lit) |-> (o_red == '0 && o_green == '0 && o_blue == '0))
        else $error("dark lamp drives a channel");
endmodule
